[rtl/assert_macros.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LXT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define LXT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lxtok_pkg.sv]
// Types, byte codes and byte classifier for the lambda expression tokenizer.
package lxtok_pkg;

  localparam int POSITION_BITS = 16;
  localparam int FIELD_BITS    = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LAMBDA = 8'h4C;

  typedef enum logic [3:0] {
    CLS_END, CLS_SPACE, CLS_DOT, CLS_DIGIT, CLS_LAMBDA,
    CLS_OTHER, CLS_LPAREN, CLS_RPAREN, CLS_EQUAL
  } cls_t;

  typedef enum logic [1:0] {
    RUN_NONE, RUN_SPACE, RUN_DIGIT, RUN_SYMBOL
  } run_t;

  typedef enum logic [3:0] {
    TK_END, TK_SPACE, TK_DOT, TK_SYMBOL, TK_LAMBDA,
    TK_LPAREN, TK_RPAREN, TK_ASSIGN, TK_ERROR
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t               kind;
    logic [FIELD_BITS-1:0]   start;
    logic [FIELD_BITS-1:0]   length;
    logic                    last;
  } token_t;

  // Up to two tokens caused by one input word.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } tok_pair_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    unique case (b) inside
      CH_NUL:                  c = CLS_END;
      CH_DOT:                  c = CLS_DOT;
      CH_LPAREN:               c = CLS_LPAREN;
      CH_RPAREN:               c = CLS_RPAREN;
      CH_LAMBDA:               c = CLS_LAMBDA;
      CH_EQUAL:                c = CLS_EQUAL;
      CH_SPACE, [CH_TAB:CH_CR]: c = CLS_SPACE;
      [CH_ZERO:CH_NINE]:       c = CLS_DIGIT;
      default:                 c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

[rtl/lxtok_core.sv]
// Run tracking and token generation: one input word in, up to two tokens out.
`include "assert_macros.svh"

module lxtok_core #(
  parameter int POSITION_BITS = lxtok_pkg::POSITION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            ch,
  output lxtok_pkg::tok_pair_t  pair
);

  lxtok_pkg::run_t            run_kind, run_kind_next;
  logic [POSITION_BITS-1:0]   run_start, run_start_next;
  logic [POSITION_BITS-1:0]   position, position_next;
  logic [POSITION_BITS-1:0]   run_len;
  lxtok_pkg::cls_t            cls;
  logic                       cont, err, pend, own;
  lxtok_pkg::tok_kind_t       pend_kind, own_kind;
  lxtok_pkg::token_t          pend_tok, own_tok;
  logic [lxtok_pkg::FIELD_BITS-1:0] pos16;

  assign cls     = lxtok_pkg::classify(ch);
  assign run_len = position - run_start;
  assign pos16   = lxtok_pkg::FIELD_BITS'(position);

  always_comb begin
    cont      = 1'b0;
    err       = 1'b0;
    pend      = 1'b0;
    pend_kind = lxtok_pkg::TK_SYMBOL;
    unique case (run_kind)
      lxtok_pkg::RUN_SPACE: begin
        if (cls == lxtok_pkg::CLS_SPACE) cont = 1'b1;
        else begin
          pend      = 1'b1;
          pend_kind = lxtok_pkg::TK_SPACE;
        end
      end
      lxtok_pkg::RUN_DIGIT: begin
        if (cls == lxtok_pkg::CLS_DIGIT) cont = 1'b1;
        else if (cls == lxtok_pkg::CLS_OTHER) err = 1'b1;
        else pend = 1'b1;
      end
      lxtok_pkg::RUN_SYMBOL: begin
        if (cls == lxtok_pkg::CLS_OTHER || cls == lxtok_pkg::CLS_DIGIT ||
            cls == lxtok_pkg::CLS_LAMBDA) cont = 1'b1;
        else pend = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    own      = 1'b1;
    own_kind = lxtok_pkg::TK_ASSIGN;
    unique case (cls)
      lxtok_pkg::CLS_END:    own_kind = lxtok_pkg::TK_END;
      lxtok_pkg::CLS_DOT:    own_kind = lxtok_pkg::TK_DOT;
      lxtok_pkg::CLS_LAMBDA: own_kind = lxtok_pkg::TK_LAMBDA;
      lxtok_pkg::CLS_LPAREN: own_kind = lxtok_pkg::TK_LPAREN;
      lxtok_pkg::CLS_RPAREN: own_kind = lxtok_pkg::TK_RPAREN;
      lxtok_pkg::CLS_EQUAL:  own_kind = lxtok_pkg::TK_ASSIGN;
      default:               own = 1'b0;  // space, digit and other open a run
    endcase
    if (cont) own = 1'b0;
    if (err) begin
      own      = 1'b1;
      own_kind = lxtok_pkg::TK_ERROR;
    end
  end

  always_comb begin
    pend_tok.kind   = pend_kind;
    pend_tok.start  = lxtok_pkg::FIELD_BITS'(run_start);
    pend_tok.length = lxtok_pkg::FIELD_BITS'(run_len);
    pend_tok.last   = ~own;
    own_tok.kind    = own_kind;
    own_tok.start   = pos16;
    own_tok.length  = lxtok_pkg::FIELD_BITS'(1);
    own_tok.last    = 1'b1;

    pair.count = {1'b0, pend} + {1'b0, own};
    pair.tok0  = pend ? pend_tok : own_tok;
    pair.tok1  = own_tok;
  end

  always_comb begin
    run_kind_next  = run_kind;
    run_start_next = run_start;
    position_next  = (position != '1) ? position + 1'b1 : position;
    if (!cont) begin
      run_kind_next = lxtok_pkg::RUN_NONE;
      if (!err) begin
        unique case (cls)
          lxtok_pkg::CLS_END: begin
            run_start_next = '0;
            position_next  = '0;
          end
          lxtok_pkg::CLS_SPACE: begin
            run_kind_next  = lxtok_pkg::RUN_SPACE;
            run_start_next = position;
          end
          lxtok_pkg::CLS_DIGIT: begin
            run_kind_next  = lxtok_pkg::RUN_DIGIT;
            run_start_next = position;
          end
          lxtok_pkg::CLS_OTHER: begin
            run_kind_next  = lxtok_pkg::RUN_SYMBOL;
            run_start_next = position;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind  <= lxtok_pkg::RUN_NONE;
      run_start <= '0;
      position  <= '0;
    end else if (fire) begin
      run_kind  <= run_kind_next;
      run_start <= run_start_next;
      position  <= position_next;
    end
  end

  `LXT_ASSERT(a_end_clears_pos, fire && (cls == lxtok_pkg::CLS_END) |=> position == '0,
              "end byte did not reset position")
  `LXT_ASSERT_ALWAYS(a_pair_last, (pair.count == 2'd2) |-> (!pair.tok0.last && pair.tok1.last),
              "last flag misplaced on token pair")
  `LXT_ASSERT(a_start_le_pos, run_start <= position,
              "run start beyond position")

endmodule

[rtl/lxtok_queue.sv]
// Small token queue that takes up to two tokens a cycle while it has room for two and returns one.
`include "assert_macros.svh"

module lxtok_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lxtok_pkg::tok_pair_t  pair,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lxtok_pkg::token_t     head_tok
);

  localparam int DEPTH    = lxtok_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  lxtok_pkg::token_t     entries [DEPTH];
  logic [PTR_BITS-1:0]   head, tail0, tail1;
  logic [CNT_BITS-1:0]   count, count_next, push_n;
  logic                  pop;

  assign space     = (count <= CNT_BITS'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign head_tok  = entries[head];
  assign pop       = out_valid & out_ready;
  assign push_n    = push ? CNT_BITS'(pair.count) : '0;
  assign tail0     = head + PTR_BITS'(count);
  assign tail1     = tail0 + 1'b1;
  assign count_next = count + push_n - CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) head <= head + 1'b1;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (push && pair.count != 2'd0) entries[tail0] <= pair.tok0;
    if (push && pair.count == 2'd2) entries[tail1] <= pair.tok1;
  end

  `LXT_ASSERT(a_no_overflow, count <= CNT_BITS'(DEPTH), "token queue overflow")
  `LXT_ASSERT(a_push_room, push_n != '0 |-> count <= CNT_BITS'(DEPTH - 2),
              "push without room for two tokens")

endmodule

[rtl/lambda_expression_tokenizer_unit.sv]
// Top level of the lambda expression tokenizer.
// A token is registered in a four-entry token queue when its byte is accepted
// and is offered from the queue head in order. Throughput: one byte per cycle
// while the queue has room for two tokens; a byte's two tokens leave singly.
// Reset (rst, synchronous): no open run, position zero, queue empty.
module lambda_expression_tokenizer_unit #(
  parameter int POSITION_BITS = lxtok_pkg::POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last
);

  lxtok_pkg::tok_pair_t pair;
  lxtok_pkg::token_t    head_tok;
  logic                 fire;

  assign fire = in_valid & in_ready;

  lxtok_core #(.POSITION_BITS(POSITION_BITS)) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ch   (ch),
    .pair (pair)
  );

  lxtok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .pair      (pair),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_tok  (head_tok)
  );

  assign token_kind   = head_tok.kind;
  assign token_start  = head_tok.start;
  assign token_length = head_tok.length;
  assign last         = head_tok.last;

endmodule
